>>> sv/tea_pkg.sv
package tea_pkg;

  localparam int unsigned TEA_ROUNDS = 32;
  localparam int unsigned WORD_W = 32;
  localparam int unsigned CFG_INDEX_W = 4;

  localparam logic [WORD_W-1:0] TEA_DELTA = 32'h9E37_79B9;

  localparam logic KIND_ENCRYPT = 1'b0;
  localparam logic KIND_DECRYPT = 1'b1;

  localparam logic [CFG_INDEX_W-1:0] KEY_IDX_0 = 4'd0;
  localparam logic [CFG_INDEX_W-1:0] KEY_IDX_1 = 4'd1;
  localparam logic [CFG_INDEX_W-1:0] KEY_IDX_2 = 4'd2;
  localparam logic [CFG_INDEX_W-1:0] KEY_IDX_3 = 4'd3;

  typedef struct packed {
    logic [WORD_W-1:0] k0;
    logic [WORD_W-1:0] k1;
    logic [WORD_W-1:0] k2;
    logic [WORD_W-1:0] k3;
  } tea_key_t;

  typedef struct packed {
    logic              valid;
    logic              kind;
    logic [WORD_W-1:0] y;
    logic [WORD_W-1:0] z;
  } tea_stage_t;

  // round sum, delta times n, evaluated at elaboration only
  function automatic logic [WORD_W-1:0] tea_sum(input int unsigned n);
    logic [2*WORD_W-1:0] p;
    p = {{WORD_W{1'b0}}, TEA_DELTA} * (2*WORD_W)'(n);
    return p[WORD_W-1:0];
  endfunction

  function automatic logic [WORD_W-1:0] tea_mix(input logic [WORD_W-1:0] x,
                                                input logic [WORD_W-1:0] sum,
                                                input logic [WORD_W-1:0] ka,
                                                input logic [WORD_W-1:0] kb);
    return ((x << 4) + ka) ^ (x + sum) ^ ((x >> 5) + kb);
  endfunction

endpackage

>>> sv/tea_block_cipher.sv
// from the accepting edge to done, a block passes through one register per half-round
// throughput: one block per cycle, busy is never raised
// the receiver cannot stall, so each result is shown for exactly one cycle on done
// synchronous reset clears the key words to zero and empties the pipeline
module tea_block_cipher
  import tea_pkg::*;
#(
  parameter int unsigned ROUNDS = TEA_ROUNDS
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  output logic                   busy,
  input  logic                   kind,
  input  logic [WORD_W-1:0]      block_first,
  input  logic [WORD_W-1:0]      block_second,
  output logic                   done,
  output logic [WORD_W-1:0]      out_first,
  output logic [WORD_W-1:0]      out_second,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [WORD_W-1:0]      cfg_data
);

  localparam int unsigned STAGES = 2 * ROUNDS;

  tea_key_t   key;
  tea_stage_t stage [0:STAGES];

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  tea_key_regs u_key (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .key       (key)
  );

  always_comb begin
    stage[0].valid = start && !busy;
    stage[0].kind  = kind;
    stage[0].y     = block_first;
    stage[0].z     = block_second;
  end

  for (genvar i = 0; i < STAGES; i++) begin : g_half
    localparam int unsigned RND = i / 2;
    tea_half_round #(
      .SUM_ENC (tea_sum(RND + 1)),
      .SUM_DEC (tea_sum(ROUNDS - RND)),
      .SECOND  ((i % 2) == 1)
    ) u_half (
      .clk       (clk),
      .rst       (rst),
      .key       (key),
      .in_stage  (stage[i]),
      .out_stage (stage[i+1])
    );
  end

  assign done       = stage[STAGES].valid;
  assign out_first  = stage[STAGES].y;
  assign out_second = stage[STAGES].z;

  a_latency: assert property (@(posedge clk) disable iff (rst)
    start && !busy |-> ##(STAGES) done)
    else $error("accepted block did not complete on time");

  a_no_phantom: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start, STAGES))
    else $error("result without a matching transaction");

endmodule

>>> sv/tea_key_regs.sv
module tea_key_regs
  import tea_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_valid,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [WORD_W-1:0]      cfg_data,
  output tea_key_t               key
);

  always_ff @(posedge clk) begin
    if (rst) begin
      key <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        KEY_IDX_0: key.k0 <= cfg_data;
        KEY_IDX_1: key.k1 <= cfg_data;
        KEY_IDX_2: key.k2 <= cfg_data;
        KEY_IDX_3: key.k3 <= cfg_data;
        default: ;
      endcase
    end
  end

  a_key3_write: assert property (@(posedge clk) disable iff (rst)
    cfg_valid && cfg_index == KEY_IDX_3 |=> key.k3 == $past(cfg_data))
    else $error("key word 3 not updated by write");

  a_unknown_index: assert property (@(posedge clk) disable iff (rst)
    cfg_valid && cfg_index != KEY_IDX_0 && cfg_index != KEY_IDX_1 &&
    cfg_index != KEY_IDX_2 && cfg_index != KEY_IDX_3 |=> $stable(key))
    else $error("write to unknown index changed the key");

endmodule

>>> sv/tea_half_round.sv
module tea_half_round
  import tea_pkg::*;
#(
  parameter logic [WORD_W-1:0] SUM_ENC = TEA_DELTA,
  parameter logic [WORD_W-1:0] SUM_DEC = TEA_DELTA,
  parameter bit                SECOND  = 1'b0
) (
  input  logic       clk,
  input  logic       rst,
  input  tea_key_t   key,
  input  tea_stage_t in_stage,
  output tea_stage_t out_stage
);

  tea_stage_t stage_next;

  always_comb begin
    stage_next = in_stage;
    if (!SECOND) begin
      if (in_stage.kind == KIND_ENCRYPT) begin
        stage_next.y = in_stage.y + tea_mix(in_stage.z, SUM_ENC, key.k0, key.k1);
      end else begin
        stage_next.z = in_stage.z - tea_mix(in_stage.y, SUM_DEC, key.k2, key.k3);
      end
    end else begin
      if (in_stage.kind == KIND_ENCRYPT) begin
        stage_next.z = in_stage.z + tea_mix(in_stage.y, SUM_ENC, key.k2, key.k3);
      end else begin
        stage_next.y = in_stage.y - tea_mix(in_stage.z, SUM_DEC, key.k0, key.k1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_stage.valid <= 1'b0;
    end else begin
      out_stage.valid <= in_stage.valid;
    end
  end

  always_ff @(posedge clk) begin
    out_stage.kind <= stage_next.kind;
    out_stage.y    <= stage_next.y;
    out_stage.z    <= stage_next.z;
  end

endmodule
